// File: hw/rtl/rntd_pkg.sv
`default_nettype none
package rntd_pkg;

	localparam int unsigned ALPHA_N   = 16;
	localparam int unsigned MAX_RADIX = 16;

	localparam logic [7:0] BYTE_SPACE = 8'd32;
	localparam logic [7:0] BYTE_DEL   = 8'd127;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_X     = 8'h78;

	localparam logic [63:0] DIGITS_LOW_RST  = 64'h3736_3534_3332_3130;
	localparam logic [63:0] DIGITS_HIGH_RST = 64'h0000_0000_0000_3938;
	localparam logic [4:0]  RADIX_RST       = 5'd10;

	localparam int unsigned REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_DIGITS_LOW  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_DIGITS_HIGH = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_RADIX       = 2'd2;

	typedef struct packed {
		logic [ALPHA_N-1:0][7:0] alpha;
		logic [4:0]              radix;
		logic                    alpha_ok;
	} cfg_t;

	typedef struct packed {
		logic        op;
		logic        empty;
		logic [63:0] value;
	} entry_t;

	function automatic logic [7:0] hex_lower(input logic [3:0] d);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = CHAR_ZERO + {4'd0, d};
		end else begin
			c = 8'h61 + {4'd0, d} - 8'd10;
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/rntd_if.sv
`default_nettype none
interface rntd_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [63:0] value;
	modport source(output valid, op, value, input ready);
	modport sink(input valid, op, value, output ready);
endinterface

interface rntd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_out;
	logic       is_last;
	logic       empty_res;
	modport source(output valid, char_out, is_last, empty_res, input ready);
	modport sink(input valid, char_out, is_last, empty_res, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/radix_number_to_digits.sv
// Radix conversion of one value per input word into a string of digit characters.
// in_ch carries op and value: op 0 writes value[31:0] in the configured alphabet
// (radix digits taken from digits_low/digits_high), op 1 writes "0x" and the
// 64-bit value in lowercase hex. out_ch returns one character per word, most
// significant first, is_last on the final one; an invalid alphabet or a zero
// pointer gives a single word with empty_res and is_last set and char_out 0.
// Registers are written over APB at byte offsets 0, 8 and 16 (64-bit data).
// A two-entry queue sits behind in_ch, so up to two words are taken ahead of
// the converter. Number mode runs an 8-bit-a-cycle restoring divider over the
// 32-bit value for each digit, pointer mode stores one hex digit per cycle; each
// character then goes through the digit store read port (states S_RD, S_DATA).
// The output register is held while out_ch.ready is low and the converter
// waits on it; the queue keeps taking words until full.
// Reset restores the decimal alphabet, radix 10, and empties queue and output.
`default_nettype none
module radix_number_to_digits #(
	parameter int unsigned MAX_DIGITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	rntd_in_if.sink          in_ch,
	rntd_out_if.source       out_ch,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic      [63:0] prdata,
	output logic             pready
);

	rntd_pkg::cfg_t   cfg;
	logic             q_valid;
	logic             q_pop;
	rntd_pkg::entry_t q_entry;

	rntd_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	rntd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.alpha_ok(cfg.alpha_ok),
		.q_valid (q_valid),
		.q_entry (q_entry),
		.q_pop   (q_pop)
	);

	rntd_back #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.q_valid(q_valid),
		.q_entry(q_entry),
		.q_pop  (q_pop),
		.out_ch (out_ch)
	);

endmodule
`default_nettype wire

// File: hw/rtl/rntd_ram.sv
`default_nettype none
module rntd_ram #(
	parameter int unsigned WIDTH = 4,
	parameter int unsigned DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: hw/rtl/rntd_cfg.sv
`default_nettype none
module rntd_cfg (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [4:0]          paddr,
	input  wire logic [63:0]         pwdata,
	output logic      [63:0]         prdata,
	output logic                     pready,
	output rntd_pkg::cfg_t           cfg
);

	logic [63:0] digits_low_q;
	logic [63:0] digits_high_q;
	logic [4:0]  radix_q;
	logic [rntd_pkg::REG_IDX_W-1:0] idx;
	logic        wr;

	assign idx    = paddr[4:3];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digits_low_q  <= rntd_pkg::DIGITS_LOW_RST;
			digits_high_q <= rntd_pkg::DIGITS_HIGH_RST;
			radix_q       <= rntd_pkg::RADIX_RST;
		end else if (wr) begin
			case (idx)
				rntd_pkg::REG_DIGITS_LOW:  digits_low_q  <= pwdata;
				rntd_pkg::REG_DIGITS_HIGH: digits_high_q <= pwdata;
				rntd_pkg::REG_RADIX:       radix_q       <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			rntd_pkg::REG_DIGITS_LOW:  prdata = digits_low_q;
			rntd_pkg::REG_DIGITS_HIGH: prdata = digits_high_q;
			rntd_pkg::REG_RADIX:       prdata = {59'd0, radix_q};
			default:                   prdata = 64'd0;
		endcase
	end

	// alphabet check: radix range, forbidden bytes, duplicates among used digits
	always_comb begin
		logic bad;
		logic [rntd_pkg::ALPHA_N-1:0][7:0] a;
		a   = {digits_high_q, digits_low_q};
		bad = (radix_q < 5'd2) || (radix_q > 5'(rntd_pkg::MAX_RADIX));
		for (int i = 0; i < rntd_pkg::ALPHA_N; i++) begin
			if (5'(i) < radix_q) begin
				if (a[i] <= rntd_pkg::BYTE_SPACE || a[i] == rntd_pkg::BYTE_DEL) begin
					bad = 1'b1;
				end
				for (int j = i + 1; j < rntd_pkg::ALPHA_N; j++) begin
					if (5'(j) < radix_q && a[j] == a[i]) begin
						bad = 1'b1;
					end
				end
			end
		end
		cfg.alpha    = a;
		cfg.radix    = radix_q;
		cfg.alpha_ok = !bad;
	end

endmodule
`default_nettype wire

// File: hw/rtl/rntd_front.sv
`default_nettype none
module rntd_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	rntd_in_if.sink          in_ch,
	input  wire logic        alpha_ok,
	output logic             q_valid,
	output rntd_pkg::entry_t q_entry,
	input  wire logic        q_pop
);

	rntd_pkg::entry_t ent_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;
	logic             push;
	rntd_pkg::entry_t ent_new;

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push        = in_ch.valid && in_ch.ready;
	assign q_valid     = (cnt_q != 2'd0);
	assign q_entry     = ent_q[rd_q];

	always_comb begin
		ent_new.op    = in_ch.op;
		ent_new.value = in_ch.value;
		ent_new.empty = in_ch.op ? (in_ch.value == 64'd0) : !alpha_ok;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= ent_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (q_pop) begin
				rd_q <= !rd_q;
			end
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/rntd_back.sv
`default_nettype none
module rntd_back #(
	parameter int unsigned MAX_DIGITS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rntd_pkg::cfg_t    cfg,
	input  wire logic              q_valid,
	input  wire rntd_pkg::entry_t  q_entry,
	output logic                   q_pop,
	rntd_out_if.source             out_ch
);

	localparam int unsigned CW = $clog2(MAX_DIGITS + 1);
	localparam int unsigned AW = $clog2(MAX_DIGITS);

	typedef enum logic [2:0] {
		S_IDLE, S_EMPTY, S_PTR, S_DIV, S_PRE0, S_PREX, S_RD, S_DATA
	} state_t;

	state_t      state_q;
	logic [63:0] work_q;
	logic [3:0]  rem_q;
	logic [1:0]  chunk_q;
	logic [CW-1:0] cnt_q;
	logic        op_q;
	logic        out_valid_q;
	logic [7:0]  out_char_q;
	logic        out_last_q;
	logic        out_empty_q;

	logic        out_free;
	logic        out_load;
	logic [4:0]  r;
	logic [7:0]  qb;
	logic [31:0] quot;
	logic        ram_we;
	logic [AW-1:0] ram_waddr;
	logic [3:0]  ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [3:0]  ram_rdata;
	logic        room;
	logic [CW-1:0] cnt_dec;
	logic [7:0]  digit_char;

	assign out_free         = !out_valid_q || out_ch.ready;
	assign out_ch.valid     = out_valid_q;
	assign out_ch.char_out  = out_char_q;
	assign out_ch.is_last   = out_last_q;
	assign out_ch.empty_res = out_empty_q;

	assign q_pop = q_valid && (state_q == S_IDLE);

	always_comb begin
		case (state_q)
			S_EMPTY, S_PRE0, S_PREX: out_load = out_free;
			S_DATA:                  out_load = 1'b1;
			default:                 out_load = 1'b0;
		endcase
	end

	// eight restoring-division steps per cycle on the top byte
	always_comb begin
		r  = {1'b0, rem_q};
		qb = 8'd0;
		for (int k = 0; k < 8; k++) begin
			r = {r[3:0], work_q[31-k]};
			if (r >= cfg.radix) begin
				r         = r - cfg.radix;
				qb[7-k]   = 1'b1;
			end
		end
	end

	assign quot      = {work_q[23:0], qb};
	assign room      = (cnt_q < CW'(MAX_DIGITS));
	assign cnt_dec   = cnt_q - CW'(1);
	assign ram_waddr = cnt_q[AW-1:0];
	assign ram_raddr = cnt_dec[AW-1:0];

	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = work_q[3:0];
		if (state_q == S_PTR) begin
			ram_we = room;
		end else if (state_q == S_DIV && chunk_q == 2'd3) begin
			ram_we    = room;
			ram_wdata = r[3:0];
		end
	end

	assign digit_char = op_q ? rntd_pkg::hex_lower(ram_rdata) : cfg.alpha[ram_rdata];

	rntd_ram #(
		.WIDTH(4),
		.DEPTH(MAX_DIGITS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			work_q      <= 64'd0;
			rem_q       <= 4'd0;
			chunk_q     <= 2'd0;
			cnt_q       <= '0;
			op_q        <= 1'b0;
			out_valid_q <= 1'b0;
			out_char_q  <= 8'd0;
			out_last_q  <= 1'b0;
			out_empty_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						op_q    <= q_entry.op;
						cnt_q   <= '0;
						rem_q   <= 4'd0;
						chunk_q <= 2'd0;
						work_q  <= q_entry.op ? q_entry.value : {32'd0, q_entry.value[31:0]};
						if (q_entry.empty) begin
							state_q <= S_EMPTY;
						end else if (q_entry.op) begin
							state_q <= S_PTR;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_EMPTY: begin
					if (out_free) begin
						out_char_q  <= 8'd0;
						out_last_q  <= 1'b1;
						out_empty_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_PTR: begin
					if (room) begin
						cnt_q <= cnt_q + CW'(1);
					end
					work_q <= {4'd0, work_q[63:4]};
					if (work_q[63:4] == 60'd0) begin
						state_q <= S_PRE0;
					end
				end
				S_DIV: begin
					work_q[31:0] <= quot;
					chunk_q      <= chunk_q + 2'd1;
					if (chunk_q == 2'd3) begin
						rem_q <= 4'd0;
						if (room) begin
							cnt_q <= cnt_q + CW'(1);
						end
						if (quot == 32'd0) begin
							state_q <= S_RD;
						end
					end else begin
						rem_q <= r[3:0];
					end
				end
				S_PRE0: begin
					if (out_free) begin
						out_char_q  <= rntd_pkg::CHAR_ZERO;
						out_last_q  <= 1'b0;
						out_empty_q <= 1'b0;
						state_q     <= S_PREX;
					end
				end
				S_PREX: begin
					if (out_free) begin
						out_char_q  <= rntd_pkg::CHAR_X;
						out_last_q  <= 1'b0;
						out_empty_q <= 1'b0;
						state_q     <= S_RD;
					end
				end
				S_RD: begin
					if (out_free) begin
						cnt_q   <= cnt_dec;
						state_q <= S_DATA;
					end
				end
				S_DATA: begin
					out_char_q  <= digit_char;
					out_last_q  <= (cnt_q == '0);
					out_empty_q <= 1'b0;
					state_q     <= (cnt_q == '0) ? S_IDLE : S_RD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/rntd_chk.sv
`default_nettype none
module rntd_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_char,
	input wire logic       out_last,
	input wire logic       out_empty,
	input wire logic       pready
);

	a_empty_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_empty |-> out_last && out_char == 8'd0)
		else $error("empty word not a lone last word");

	a_empty_not_mid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> !out_valid || !out_empty)
		else $error("empty word inside a string");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char)
			&& $stable(out_last) && $stable(out_empty))
		else $error("stalled output word changed");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind radix_number_to_digits rntd_chk u_rntd_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_char (out_ch.char_out),
	.out_last (out_ch.is_last),
	.out_empty(out_ch.empty_res),
	.pready   (pready)
);
`default_nettype wire

// File: dv/rntd_tb_pkg.sv
package rntd_tb_pkg;
	import rntd_pkg::*;

	localparam logic OP_NUMBER  = 1'b0;
	localparam logic OP_POINTER = 1'b1;

	// index past the register list, writes are dropped
	localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic [7:0] char_b;
		logic       is_last;
		logic       empty_res;
	} char_word_t;

endpackage

// File: dv/rntd_checker.sv
module rntd_checker
	import rntd_pkg::*, rntd_tb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	rntd_in_if               in_ch,
	rntd_out_if              out_ch,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [63:0] pwdata,
	input  wire logic        pready,
	output int               errors,
	output int               pending
);

	localparam logic [7:0] CHAR_A = 8'h61;

	logic [63:0] digits_lo = DIGITS_LOW_RST;
	logic [63:0] digits_hi = DIGITS_HIGH_RST;
	logic [4:0]  radix_cfg = RADIX_RST;
	char_word_t  char_q[$];
	int          err_cnt = 0;

	function automatic logic [7:0] alpha_byte(input int idx);
		return (idx < 8) ? digits_lo[8*idx +: 8] : digits_hi[8*(idx-8) +: 8];
	endfunction

	function automatic bit alphabet_valid();
		if (radix_cfg < 2 || radix_cfg > MAX_RADIX) begin
			return 1'b0;
		end
		for (int i = 0; i < radix_cfg; i++) begin
			if (alpha_byte(i) <= BYTE_SPACE || alpha_byte(i) == BYTE_DEL) begin
				return 1'b0;
			end
			for (int j = i + 1; j < radix_cfg; j++) begin
				if (alpha_byte(j) == alpha_byte(i)) begin
					return 1'b0;
				end
			end
		end
		return 1'b1;
	endfunction

	function automatic void predict_chars(input logic op, input logic [63:0] val);
		logic [63:0] rest;
		logic [63:0] base;
		logic [3:0]  dstore [64];
		int          ndig;
		char_word_t  w;
		ndig = 0;
		if ((op == OP_NUMBER && !alphabet_valid()) || (op == OP_POINTER && val == '0)) begin
			char_q.push_back('{char_b: 8'd0, is_last: 1'b1, empty_res: 1'b1});
			return;
		end
		base = (op == OP_NUMBER) ? 64'(radix_cfg) : 64'd16;
		rest = (op == OP_NUMBER) ? {32'd0, val[31:0]} : val;
		// least significant digit first
		do begin
			dstore[ndig] = 4'(rest % base);
			rest = rest / base;
			ndig++;
		end while (rest != 0);
		if (op == OP_POINTER) begin
			char_q.push_back('{char_b: CHAR_ZERO, is_last: 1'b0, empty_res: 1'b0});
			char_q.push_back('{char_b: CHAR_X, is_last: 1'b0, empty_res: 1'b0});
		end
		for (int i = ndig - 1; i >= 0; i--) begin
			if (op == OP_NUMBER) begin
				w.char_b = alpha_byte(dstore[i]);
			end else if (dstore[i] < 4'd10) begin
				w.char_b = CHAR_ZERO + dstore[i];
			end else begin
				w.char_b = CHAR_A + dstore[i] - 8'd10;
			end
			w.is_last   = (i == 0);
			w.empty_res = 1'b0;
			char_q.push_back(w);
		end
	endfunction

	always @(posedge clk) begin
		char_word_t got;
		char_word_t want;
		if (!arst_n) begin
			digits_lo = DIGITS_LOW_RST;
			digits_hi = DIGITS_HIGH_RST;
			radix_cfg = RADIX_RST;
			char_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:3])
					REG_DIGITS_LOW:  digits_lo = pwdata;
					REG_DIGITS_HIGH: digits_hi = pwdata;
					REG_RADIX:       radix_cfg = pwdata[4:0];
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				got = '{char_b: out_ch.char_out, is_last: out_ch.is_last,
					empty_res: out_ch.empty_res};
				if (char_q.size() == 0) begin
					if (err_cnt < 10) begin
						$display("unexpected word: char %h last %b empty %b",
							got.char_b, got.is_last, got.empty_res);
					end
					err_cnt++;
				end else begin
					want = char_q.pop_front();
					if (got.char_b !== want.char_b || got.is_last !== want.is_last ||
						got.empty_res !== want.empty_res) begin
						if (err_cnt < 10) begin
							$display("mismatch: char %h/%h last %b/%b empty %b/%b (exp/act)",
								want.char_b, got.char_b, want.is_last, got.is_last,
								want.empty_res, got.empty_res);
						end
						err_cnt++;
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				predict_chars(in_ch.op, in_ch.value);
			end
		end
		errors  <= err_cnt;
		pending <= char_q.size();
	end

endmodule

// File: dv/tb_top.sv
module tb_top;
	import rntd_pkg::*;
	import rntd_tb_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;
	int          tx_idle_pct;
	int          rx_idle_pct;
	int          errors;
	int          pending;
	int          quiet_cycles = 0;

	rntd_in_if  in_ch();
	rntd_out_if out_ch();

	radix_number_to_digits i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	rntd_checker i_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.pready  (pready),
		.errors  (errors),
		.pending (pending)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
			(psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_word(input logic op, input logic [63:0] val);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.op    <= op;
		in_ch.value <= val;
		do begin
			@(posedge clk);
		end while (!in_ch.ready);
	endtask

	// drain: hold the sender until every character is back
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [63:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_cfg(input logic [63:0] lo, input logic [63:0] hi, input logic [4:0] rdx);
		wait_idle();
		apb_write(REG_DIGITS_LOW, lo);
		apb_write(REG_DIGITS_HIGH, hi);
		apb_write(REG_RADIX, {59'd0, rdx});
	endtask

	initial begin
		logic [7:0]  ab [16];
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] val;
		logic [4:0]  rdx;
		logic        op;
		int          j;
		bit          clash;
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		in_ch.valid  = 1'b0;
		in_ch.op     = OP_NUMBER;
		in_ch.value  = '0;
		out_ch.ready = 1'b0;
		tx_idle_pct  = 22;
		rx_idle_pct  = 79;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// decimal after reset, then pointer words
		send_word(OP_NUMBER, 64'd0);
		send_word(OP_NUMBER, '1);
		send_word(OP_NUMBER, 64'h1_0000_0000);
		send_word(OP_NUMBER, 64'h8000_0000);
		send_word(OP_POINTER, 64'd0);
		send_word(OP_POINTER, '1);
		send_word(OP_POINTER, 64'd1);
		send_word(OP_POINTER, 64'h0123_4567_89ab_cdef);

		// binary, longest output
		set_cfg(DIGITS_LOW_RST, DIGITS_HIGH_RST, 5'd2);
		send_word(OP_NUMBER, 64'hffff_ffff);
		send_word(OP_NUMBER, 64'd0);

		// 16 digits, bytes 33, 126, 128, 255 in use
		set_cfg(64'h4746_4544_ff80_7e21, 64'h4f4e_4d4c_4b4a_4948, 5'd16);
		send_word(OP_NUMBER, 64'hffff_ffff);
		send_word(OP_NUMBER, 64'h1234_5678);

		// bad radix
		set_cfg(DIGITS_LOW_RST, DIGITS_HIGH_RST, 5'd0);
		send_word(OP_NUMBER, 64'd12345);
		send_word(OP_POINTER, 64'hdead);
		set_cfg(DIGITS_LOW_RST, DIGITS_HIGH_RST, 5'd1);
		send_word(OP_NUMBER, 64'd7);
		set_cfg(DIGITS_LOW_RST, DIGITS_HIGH_RST, 5'd17);
		send_word(OP_NUMBER, 64'd7);
		set_cfg(DIGITS_LOW_RST, DIGITS_HIGH_RST, 5'd31);
		send_word(OP_NUMBER, 64'd7);

		// bad bytes: space, DEL, zero byte, duplicate
		set_cfg(64'h3736_3534_3332_2030, DIGITS_HIGH_RST, RADIX_RST);
		send_word(OP_NUMBER, 64'd42);
		set_cfg(DIGITS_LOW_RST, 64'h7f38, RADIX_RST);
		send_word(OP_NUMBER, 64'd42);
		set_cfg(DIGITS_LOW_RST, DIGITS_HIGH_RST, 5'd11);
		send_word(OP_NUMBER, 64'd42);
		set_cfg(DIGITS_LOW_RST, 64'h3038, RADIX_RST);
		send_word(OP_NUMBER, 64'd42);

		set_cfg(DIGITS_LOW_RST, DIGITS_HIGH_RST, RADIX_RST);
		apb_write(REG_SPARE, '1);
		send_word(OP_NUMBER, 64'd4000000000);

		for (int ph = 0; ph < 3; ph++) begin
			tx_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 79 : 0;
			rx_idle_pct = (ph == 0) ? 79 : (ph == 1) ? 22 : 0;
			for (int n = 0; n < 110; n++) begin
				if (n % 22 == 0) begin
					j = $urandom_range(99);
					if (j < 20) begin
						rdx = 5'd2;
					end else if (j < 40) begin
						rdx = 5'd16;
					end else if (j < 90) begin
						rdx = 5'($urandom_range(16, 2));
					end else if (j < 95) begin
						rdx = 5'($urandom_range(1));
					end else begin
						rdx = 5'($urandom_range(31, 17));
					end
					for (int i = 0; i < 16; i++) begin
						do begin
							ab[i] = 8'($urandom_range(255, 33));
							clash = (ab[i] == BYTE_DEL);
							for (int k = 0; k < i; k++) begin
								if (ab[k] == ab[i]) begin
									clash = 1'b1;
								end
							end
						end while (clash);
					end
					if (rdx >= 2 && $urandom_range(99) < 12) begin
						j = $urandom_range(rdx - 1);
						case ($urandom_range(2))
							0:       ab[j] = 8'($urandom_range(32));
							1:       ab[j] = BYTE_DEL;
							default: ab[j] = ab[(j == 0) ? 1 : 0];
						endcase
					end
					for (int i = 0; i < 8; i++) begin
						lo[8*i +: 8] = ab[i];
						hi[8*i +: 8] = ab[i+8];
					end
					if ($urandom_range(99) < 4) begin
						lo = {$urandom(), $urandom()};
						hi = {$urandom(), $urandom()};
					end
					set_cfg(lo, hi, rdx);
				end
				op  = 1'($urandom_range(1));
				val = {$urandom(), $urandom()};
				case ($urandom_range(9))
					0:          val = '0;
					1:          val = '1;
					2, 3, 4, 5: val = val >> $urandom_range(63);
					default: ;
				endcase
				send_word(op, val);
			end
		end

		wait_idle();
		repeat (40) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/rntd_pkg.sv
hw/rtl/rntd_if.sv
hw/rtl/rntd_ram.sv
hw/rtl/rntd_cfg.sv
hw/rtl/rntd_front.sv
hw/rtl/rntd_back.sv
hw/rtl/radix_number_to_digits.sv
hw/rtl/rntd_chk.sv
dv/rntd_tb_pkg.sv
dv/rntd_checker.sv
dv/tb_top.sv
